FILE: hw/rtl/ath_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the allocation tracker hash table.
// Used by ath_ctrl, ath_datapath and allocation_tracker_hash_table_top.

package ath_pkg;

  // field widths fixed by the word formats
  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 48;
  localparam int HASH_SHIFT = 12;
  localparam int HASH_W     = ADDR_W - HASH_SHIFT;
  // home slot remainder is worked out DIGIT_W bits per cycle
  localparam int DIGIT_W    = 4;
  localparam int HASH_STEPS = HASH_W / DIGIT_W;
  localparam int STEP_W     = $clog2(HASH_STEPS);

  // operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] block_address;
    logic [SIZE_W-1:0] block_size;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [SIZE_W-1:0] found_size;
  } out_word_t;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic              used;
    logic              tomb;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;      // write an empty slot at the clear pointer
    logic load;       // capture the input word
    logic hash_step;  // one remainder step
    logic refuse;     // record a table-full result
    logic read_home;  // read the home slot, start the probe walk
    logic check;      // evaluate the slot just read
    logic out_load;   // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic hash_done;
    logic full;
    logic is_insert;
    logic probe_end;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/ath_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the allocation tracker: clear pass, hash, probe walk, result.
// Depends on ath_pkg.

module ath_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ath_pkg::sts_t sts,
  output ath_pkg::cmd_t cmd
);

  ath_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ath_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ath_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = ath_pkg::S_IDLE;
      end
      ath_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ath_pkg::S_HASH;
        end
      end
      ath_pkg::S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) begin
          if (sts.is_insert && sts.full) begin
            cmd.refuse = 1'b1;
            state_nxt  = ath_pkg::S_FINISH;
          end else begin
            state_nxt = ath_pkg::S_READ;
          end
        end
      end
      ath_pkg::S_READ: begin
        cmd.read_home = 1'b1;
        state_nxt     = ath_pkg::S_CHECK;
      end
      ath_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.probe_end) state_nxt = ath_pkg::S_FINISH;
      end
      ath_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ath_pkg::S_IDLE;
        end
      end
      default: state_nxt = ath_pkg::S_CLEAR;
    endcase
  end

endmodule

FILE: hw/rtl/ath_datapath.sv
`timescale 1ns / 1ps
// Datapath of the allocation tracker: slot memory, home slot remainder,
// probe pointer, live count and output register. Depends on ath_pkg.

module ath_datapath #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ath_pkg::cmd_t     cmd,
  output ath_pkg::sts_t     sts,
  input  ath_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output ath_pkg::out_word_t out_word
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY / 2 + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  HALF      = CNT_W'(CAPACITY / 2);
  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

  // captured item
  logic                       kind_r;
  logic [ath_pkg::ADDR_W-1:0] addr_r;
  logic [ath_pkg::SIZE_W-1:0] size_r;

  logic [SLOT_W-1:0] home;
  logic              hash_done;
  logic [SLOT_W-1:0] probe_r, probe_next;
  logic [SLOT_W-1:0] n_r;
  logic [SLOT_W-1:0] clr_r;
  logic [CNT_W-1:0]  live_r;

  ath_pkg::entry_t    mem [CAPACITY];
  ath_pkg::entry_t    rd_q;
  ath_pkg::entry_t    wr_data;
  logic [SLOT_W-1:0]  rd_addr, wr_addr;
  logic               wr_en;

  logic is_insert, take, stop, last, probe_end;
  ath_pkg::out_word_t res_r, res_nxt;
  logic               out_valid_r;

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_word.kind;
      addr_r <= in_word.block_address;
      size_r <= in_word.block_size;
    end
  end

  // home slot: address page number modulo the table size
  generate
    if (IS_POW2) begin : g_mask
      assign home      = addr_r[ath_pkg::HASH_SHIFT +: SLOT_W];
      assign hash_done = 1'b1;
    end else begin : g_rem
      localparam logic [SLOT_W:0] CAP_EXT = (SLOT_W + 1)'(CAPACITY);
      logic [ath_pkg::HASH_W-1:0] hash_r, hash_nxt;
      logic [SLOT_W-1:0]          rem_r, rem_nxt;
      logic [ath_pkg::STEP_W-1:0] step_r;

      // restoring remainder, DIGIT_W bits per step, MSB first
      always_comb begin
        logic [SLOT_W:0] t;
        rem_nxt = rem_r;
        for (int i = 0; i < ath_pkg::DIGIT_W; i++) begin
          t = {rem_nxt, hash_r[ath_pkg::HASH_W-1-i]};
          if (t >= CAP_EXT) t = t - CAP_EXT;
          rem_nxt = t[SLOT_W-1:0];
        end
        hash_nxt = hash_r << ath_pkg::DIGIT_W;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          step_r <= '0;
        end else if (cmd.load) begin
          step_r <= '0;
        end else if (cmd.hash_step) begin
          step_r <= step_r + 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.load) begin
          hash_r <= in_word.block_address[ath_pkg::ADDR_W-1:ath_pkg::HASH_SHIFT];
          rem_r  <= '0;
        end else if (cmd.hash_step) begin
          hash_r <= hash_nxt;
          rem_r  <= rem_nxt;
        end
      end

      assign home      = rem_r;
      assign hash_done = step_r == ath_pkg::STEP_W'(ath_pkg::HASH_STEPS - 1);
    end
  endgenerate

  // probe pointer and walk length
  assign probe_next = (probe_r == LAST_SLOT) ? '0 : probe_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
      n_r     <= '0;
    end else if (cmd.read_home) begin
      probe_r <= home;
      n_r     <= '0;
    end else if (cmd.check && !probe_end) begin
      probe_r <= probe_next;
      n_r     <= n_r + 1'b1;
    end
  end

  // clear pointer for the pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // slot decision on the word read for the current probe
  assign is_insert = kind_r == ath_pkg::KIND_INSERT;
  assign take = is_insert ? (!rd_q.used || rd_q.tomb)
                          : (rd_q.used && !rd_q.tomb && rd_q.addr == addr_r);
  assign stop      = !is_insert && !rd_q.used;
  assign last      = n_r == LAST_SLOT;
  assign probe_end = take || stop || last;

  // slot memory write: clear pass, new entry, or tombstone
  assign wr_en   = cmd.clear || (cmd.check && take);
  assign wr_addr = cmd.clear ? clr_r : probe_r;
  always_comb begin
    wr_data = '0;
    if (!cmd.clear) begin
      if (is_insert) begin
        wr_data.used = 1'b1;
        wr_data.tomb = 1'b0;
        wr_data.addr = addr_r;
        wr_data.size = size_r;
      end else begin
        wr_data      = rd_q;
        wr_data.tomb = 1'b1;
      end
    end
  end

  // read the home slot first, then always one slot ahead
  assign rd_addr = cmd.read_home ? home : probe_next;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

  // live entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (cmd.check && take) begin
      if (is_insert) begin
        live_r <= live_r + 1'b1;
      end else if (live_r != '0) begin
        live_r <= live_r - 1'b1;
      end
    end
  end

  // result word
  always_comb begin
    res_nxt = res_r;
    if (cmd.refuse) begin
      res_nxt.status     = ath_pkg::STAT_FULL;
      res_nxt.found_size = '0;
    end else if (cmd.check && probe_end) begin
      res_nxt.found_size = '0;
      if (take) begin
        res_nxt.status = ath_pkg::STAT_DONE;
        if (!is_insert) res_nxt.found_size = rd_q.size;
      end else if (stop || !is_insert) begin
        res_nxt.status = ath_pkg::STAT_MISS;
      end else begin
        res_nxt.status = ath_pkg::STAT_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_word <= res_r;
  end

  assign out_valid = out_valid_r;

  // status to the controller
  assign sts.clear_last = clr_r == LAST_SLOT;
  assign sts.hash_done  = hash_done;
  assign sts.full       = live_r >= HALF;
  assign sts.is_insert  = is_insert;
  assign sts.probe_end  = probe_end;
  assign sts.out_free   = !out_valid_r || !out_stall;

endmodule

FILE: hw/rtl/allocation_tracker_hash_table_top.sv
`timescale 1ns / 1ps
// Top level of the allocation tracker hash table.
// Depends on ath_pkg, ath_ctrl and ath_datapath.

// Tracks live memory blocks keyed by start address in an open-addressing
// table of CAPACITY slots with linear probing and tombstones. An insert word
// (kind 0) stores address and size in the first empty or tombstoned slot from
// the home slot (address >> 12) mod CAPACITY, and is refused with status full
// once half the slots are live. A lookup word (kind 1) removes the first live
// matching entry and returns its size, or not-found at an empty slot or after
// CAPACITY probes. One word is in work at a time; a finished result waits in
// the output register while the next word is taken. Each word passes through
// the load, hash, home slot read, probe and finish states, one slot probed per
// cycle through the registered slot memory read; with a power-of-two CAPACITY
// the home slot is taken from the address bits, other sizes work the remainder
// out four bits a cycle. A refused insert skips the probe walk. After reset the
// slot memory is cleared one slot a cycle, and no word is taken before that ends.

module allocation_tracker_hash_table_top #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ath_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ath_pkg::out_word_t out_word
);

  ath_pkg::cmd_t cmd;
  ath_pkg::sts_t sts;

  ath_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ath_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: sim/tb_allocation_tracker_hash_table_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for allocation_tracker_hash_table_top.
// Depends on ath_pkg and the block's RTL; expected results are predicted in place.

module tb_allocation_tracker_hash_table_top;

  localparam int CAPACITY       = 1024;
  localparam int HALF_LOAD      = CAPACITY / 2;
  localparam int SLOT_W         = $clog2(CAPACITY);
  localparam int CLUSTER_WORDS  = 80;
  localparam int REMOVE_WORDS   = 50;
  localparam int CHURN_WORDS    = 300;
  localparam int TAIL_WORDS     = 80;
  localparam int DRAIN_CYCLES   = 40;
  // covers the clearing pass and a full probe walk with stalls, several times over
  localparam int WATCHDOG_LIMIT = 20000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ath_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ath_pkg::out_word_t out_word;

  allocation_tracker_hash_table_top #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted table contents; every slot starts empty
  logic [ath_pkg::ADDR_W-1:0] slot_addr [CAPACITY];
  logic [ath_pkg::SIZE_W-1:0] slot_size [CAPACITY];
  bit                         slot_used [CAPACITY];
  bit                         slot_tomb [CAPACITY];
  int                         live_entries = 0;

  ath_pkg::in_word_t          pending_words[$];
  ath_pkg::out_word_t         expected_results[$];
  logic [ath_pkg::ADDR_W-1:0] live_addrs[$];    // addresses the stimulus believes are stored
  ath_pkg::out_word_t         oldest;
  int                         mismatch_count = 0;
  int                         stuck_cycles   = 0;
  int unsigned                in_gap         = 0;
  int unsigned                stall_left     = 0;

  // applies one word to the predicted table and returns its result word
  function automatic ath_pkg::out_word_t apply_word(ath_pkg::in_word_t w);
    ath_pkg::out_word_t r;
    int unsigned        s;
    int unsigned        n;
    bit                 stop;
    r.status     = ath_pkg::STAT_MISS;
    r.found_size = '0;
    s    = 32'((w.block_address >> ath_pkg::HASH_SHIFT) % CAPACITY);
    n    = 0;
    stop = 1'b0;
    if (w.kind == ath_pkg::KIND_INSERT) begin
      // refused at half load; otherwise first empty or tombstoned slot
      r.status = ath_pkg::STAT_FULL;
      if (live_entries < HALF_LOAD) begin
        while (n < CAPACITY && !stop) begin
          if (!slot_used[s] || slot_tomb[s]) begin
            slot_addr[s] = w.block_address;
            slot_size[s] = w.block_size;
            slot_used[s] = 1'b1;
            slot_tomb[s] = 1'b0;
            live_entries++;
            r.status = ath_pkg::STAT_DONE;
            stop = 1'b1;
          end else begin
            s = (s + 1) % CAPACITY;
            n++;
          end
        end
      end
    end else begin
      // walk until an empty slot; first live match is removed
      while (n < CAPACITY && !stop) begin
        if (!slot_used[s]) begin
          stop = 1'b1;
        end else if (!slot_tomb[s] && slot_addr[s] == w.block_address) begin
          r.status     = ath_pkg::STAT_DONE;
          r.found_size = slot_size[s];
          slot_tomb[s] = 1'b1;
          if (live_entries > 0) live_entries--;
          stop = 1'b1;
        end else begin
          s = (s + 1) % CAPACITY;
          n++;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [47:0] random_48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // random address whose home slot is the given one
  function automatic logic [ath_pkg::ADDR_W-1:0] addr_at(int unsigned slot);
    logic [ath_pkg::ADDR_W-1:0] a;
    a = random_48();
    a[ath_pkg::HASH_SHIFT +: SLOT_W] = SLOT_W'(slot);
    return a;
  endfunction

  task automatic queue_insert(logic [ath_pkg::ADDR_W-1:0] addr,
                              logic [ath_pkg::SIZE_W-1:0] bytes);
    ath_pkg::in_word_t w;
    w.kind          = ath_pkg::KIND_INSERT;
    w.block_address = addr;
    w.block_size    = bytes;
    pending_words.push_back(w);
    if (live_addrs.size() < HALF_LOAD) live_addrs.push_back(addr);
  endtask

  task automatic queue_lookup(logic [ath_pkg::ADDR_W-1:0] addr);
    ath_pkg::in_word_t w;
    int                idx;
    w.kind          = ath_pkg::KIND_LOOKUP;
    w.block_address = addr;
    w.block_size    = random_48();
    pending_words.push_back(w);
    idx = -1;
    foreach (live_addrs[i]) if (idx < 0 && live_addrs[i] == addr) idx = i;
    if (idx >= 0) live_addrs.delete(idx);
  endtask

  // one insert for each home slot in [first, first+count), wrapping, in random order
  task automatic insert_shuffled(int unsigned first, int unsigned count);
    int unsigned slots[$];
    int unsigned idx;
    for (int unsigned k = 0; k < count; k++) slots.push_back((first + k) % CAPACITY);
    while (slots.size() != 0) begin
      idx = $urandom_range(0, slots.size() - 1);
      queue_insert(addr_at(slots[idx]), random_48());
      slots.delete(idx);
    end
  endtask

  // idling is off in stretches and in the tail of the run
  function automatic bit idling_on();
    return pending_words.size() >= TAIL_WORDS && (pending_words.size() / 64) % 4 != 0;
  endfunction

  // input driver: holds a word until accepted, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (in_valid && idling_on() && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 2);
      end else begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
      end
    end
  end

  // result side back-pressure in short bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!out_stall && idling_on() && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check each accepted result, predict each accepted input word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no word pending: status %0d, found_size 0x%0h",
                 out_word.status, out_word.found_size);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_word.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_word.status);
            mismatch_count++;
          end
          if (out_word.found_size !== oldest.found_size) begin
            $error("found_size: expected 0x%0h, got 0x%0h",
                   oldest.found_size, out_word.found_size);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_word(in_word));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    while (stuck_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned hot;
    logic [ath_pkg::ADDR_W-1:0] addr;

    // directed: empty-table miss, extremes, wrap at the last slot, duplicates
    queue_lookup(48'h0);
    queue_insert(48'h0, 48'h0);
    queue_insert(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_insert(48'h0000_003F_F000, 48'h0000_0000_0123);   // wraps past slot 0
    queue_insert(48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555);   // duplicate address
    queue_lookup(48'h0000_003F_F000);
    queue_lookup(48'hFFFF_FFFF_FFFF);
    queue_lookup(48'hFFFF_FFFF_FFFF);                       // second copy, past tombstones
    queue_lookup(48'hFFFF_FFFF_FFFF);                       // gone: miss at empty slot
    queue_insert(48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA);
    queue_insert(48'h0000_003F_F001, 48'h0000_0000_0001);   // reuses a tombstone
    queue_lookup(48'h0000_003F_F001);
    queue_lookup(48'h0);
    queue_lookup(48'hAAAA_AAAA_AAAA);
    queue_lookup(48'h5555_5555_5555);

    // a run of used slots straddling the wrap point
    insert_shuffled(CAPACITY - CLUSTER_WORDS / 2, CLUSTER_WORDS);

    // thin the run out, leaving tombstones, with a few misses that walk it
    for (int k = 0; k < REMOVE_WORDS; k++) begin
      if ($urandom_range(0, 7) == 0 || live_addrs.size() == 0) begin
        queue_lookup(addr_at((CAPACITY - CLUSTER_WORDS / 2 +
                              $urandom_range(0, CLUSTER_WORDS - 1)) % CAPACITY));
      end else begin
        queue_lookup(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end
    end

    // churn: clustered homes, duplicates, hits and misses
    for (int k = 0; k < CHURN_WORDS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (pick < 5 && live_addrs.size() != 0) begin
          addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        end else if (pick < 25) begin
          hot  = $urandom_range(0, 3);
          addr = addr_at(hot == 0 ? CAPACITY - 1 : hot == 1 ? 0 :
                         hot == 2 ? HALF_LOAD - 1 : HALF_LOAD);
        end else begin
          addr = addr_at($urandom_range(0, CAPACITY - 1));
        end
        queue_insert(addr, random_48());
      end else if (pick < 85 && live_addrs.size() != 0) begin
        queue_lookup(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else begin
        queue_lookup(random_48());
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: allocation_tracker_hash_table_top.f
hw/rtl/ath_pkg.sv
hw/rtl/ath_ctrl.sv
hw/rtl/ath_datapath.sv
hw/rtl/allocation_tracker_hash_table_top.sv
sim/tb_allocation_tracker_hash_table_top.sv
